// ----- rtl/dwbu_pkg.sv -----
// Shared types and constants for the debug watchpoint and breakpoint unit.
package dwbu_pkg;

    // Default table depths.
    localparam int BP_ENTRIES_DEF = 16;
    localparam int WP_ENTRIES_DEF = 16;

    // Operation carried by one input beat.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_DCHECK = 2'd2,
        OP_PCHECK = 2'd3
    } t_op;

    // Point types on the input.
    localparam logic [2:0] PT_BP_LAST = 3'd1;
    localparam logic [2:0] PT_WRITE   = 3'd2;
    localparam logic [2:0] PT_ACCESS  = 3'd4;

    // Watchpoint type codes as stored in the table.
    localparam logic [1:0] WPT_WRITE  = 2'd0;
    localparam logic [1:0] WPT_READ   = 2'd1;
    localparam logic [1:0] WPT_ACCESS = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_FULL        = 2'd2;

    localparam logic [31:0] IO_SPACE_BIT = 32'h8000_0000;
    localparam logic [15:0] BP_KIND_HIT  = 16'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input beat
        logic rd_en;     // read the table entry at the scan index
        logic out_load;  // move the finished result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic no_scan;   // the item needs no table walk
        logic use_bp;    // the walk goes over the breakpoint table
        logic out_free;  // the output register can take a result
    } t_stat;

endpackage

// ----- rtl/debug_watchpoint_breakpoint_unit_core.sv -----
// An insert, remove or check walks its table one entry per cycle through a single memory
// read port: the breakpoint table (BP_ENTRIES entries) for breakpoint inserts/removes and
// program counter checks, and the watchpoint table (WP_ENTRIES entries) for watchpoint
// inserts/removes and data checks. An unsupported type skips the walk.
// A new item is taken only once the last result has moved into the output register.
// Reset (synchronous, active low) clears every valid bit of both tables and the output valid flag.
module debug_watchpoint_breakpoint_unit_core import dwbu_pkg::*; #(
    parameter int BP_ENTRIES = BP_ENTRIES_DEF,
    parameter int WP_ENTRIES = WP_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_point_type,
    input  logic [31:0] i_address,
    input  logic [15:0] i_size_or_kind,
    input  logic        i_access_is_write,
    input  logic        i_io_space,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_hit
);

    // The scan counter is sized for the deeper of the two tables.
    localparam int MAXN = (BP_ENTRIES > WP_ENTRIES) ? BP_ENTRIES : WP_ENTRIES;
    localparam int CW   = (MAXN > 1) ? $clog2(MAXN) : 1;

    t_cmd          cmd;
    t_stat         stat;
    logic [CW-1:0] rd_idx;

    // The controller sequences one beat at a time: capture, decode, table walk, pipeline
    // drain and hand-off to the output register.
    dwbu_ctrl #(
        .BP_ENTRIES (BP_ENTRIES),
        .WP_ENTRIES (WP_ENTRIES),
        .CW         (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_rd_idx   (rd_idx)
    );

    // The datapath holds the tables and compares one entry per cycle. Inserts take the
    // first free slot seen during the walk, removes clear every exact match, and checks
    // raise a sticky match flag. The output register lets the next beat in while the
    // previous result still waits downstream.
    dwbu_dp #(
        .BP_ENTRIES (BP_ENTRIES),
        .WP_ENTRIES (WP_ENTRIES),
        .CW         (CW)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_rd_idx          (rd_idx),
        .i_kind            (i_kind),
        .i_point_type      (i_point_type),
        .i_address         (i_address),
        .i_size_or_kind    (i_size_or_kind),
        .i_access_is_write (i_access_is_write),
        .i_io_space        (i_io_space),
        .o_stat            (stat),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_hit             (o_hit)
    );

endmodule

// ----- rtl/dwbu_dp.sv -----
// Datapath: item registers, point tables, entry compare and output register.
module dwbu_dp import dwbu_pkg::*; #(
    parameter int BP_ENTRIES = BP_ENTRIES_DEF,
    parameter int WP_ENTRIES = WP_ENTRIES_DEF,
    parameter int CW         = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [CW-1:0] i_rd_idx,
    input  logic [1:0]    i_kind,
    input  logic [2:0]    i_point_type,
    input  logic [31:0]   i_address,
    input  logic [15:0]   i_size_or_kind,
    input  logic          i_access_is_write,
    input  logic          i_io_space,
    output t_stat         o_stat,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [1:0]    o_status,
    output logic          o_hit
);

    localparam int BP_IW = (BP_ENTRIES > 1) ? $clog2(BP_ENTRIES) : 1;
    localparam int WP_IW = (WP_ENTRIES > 1) ? $clog2(WP_ENTRIES) : 1;

    // Latched item.
    t_op         r_op;
    logic [2:0]  r_ptype;
    logic [31:0] r_addr;
    logic [15:0] r_sk;
    logic        r_wr;
    logic        r_io;

    // Tables: valid bits in flops, payload in memories.
    logic [BP_ENTRIES-1:0] r_bp_valid;
    logic [WP_ENTRIES-1:0] r_wp_valid;
    logic [47:0] r_bp_mem [BP_ENTRIES];
    logic [49:0] r_wp_mem [WP_ENTRIES];

    // Read stage.
    logic [47:0]   r_rd_bp;
    logic [49:0]   r_rd_wp;
    logic          r_cmp_en;
    logic [CW-1:0] r_cmp_idx;

    logic        r_found;
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic        r_hit;

    logic             is_bp_type;
    logic             no_scan;
    logic             use_bp;
    logic [BP_IW-1:0] bp_ci;
    logic [WP_IW-1:0] wp_ci;
    logic [31:0]      rd_bp_addr;
    logic [15:0]      rd_bp_kind;
    logic [1:0]       rd_wp_type;
    logic [31:0]      rd_wp_base;
    logic [15:0]      rd_wp_len;
    logic [2:0]       type_diff;
    logic [1:0]       new_wp_type;
    logic [31:0]      chk_addr;
    logic [32:0]      wp_end;
    logic             bp_ok;
    logic             wp_ok;
    logic             bp_same;
    logic             wp_same;
    logic             bp_pc_hit;
    logic             wp_type_ok;
    logic             wp_data_hit;
    logic             ins_slot;
    logic             ins_write;
    logic             out_free;
    logic [1:0]       n_status;

    always_comb begin
        is_bp_type  = (r_ptype <= PT_BP_LAST);
        no_scan     = ((r_op == OP_INSERT) || (r_op == OP_REMOVE)) && (r_ptype > PT_ACCESS);
        use_bp      = (r_op == OP_PCHECK) ||
                      (((r_op == OP_INSERT) || (r_op == OP_REMOVE)) && is_bp_type);
        type_diff   = r_ptype - PT_WRITE;
        new_wp_type = type_diff[1:0];
        chk_addr    = r_io ? (r_addr | IO_SPACE_BIT) : r_addr;

        bp_ci       = r_cmp_idx[BP_IW-1:0];
        wp_ci       = r_cmp_idx[WP_IW-1:0];
        rd_bp_addr  = r_rd_bp[47:16];
        rd_bp_kind  = r_rd_bp[15:0];
        rd_wp_type  = r_rd_wp[49:48];
        rd_wp_base  = r_rd_wp[47:16];
        rd_wp_len   = r_rd_wp[15:0];

        bp_ok       = use_bp && r_bp_valid[bp_ci];
        wp_ok       = !use_bp && r_wp_valid[wp_ci];
        bp_same     = bp_ok && (rd_bp_addr == r_addr) && (rd_bp_kind == r_sk);
        wp_same     = wp_ok && (rd_wp_type == new_wp_type) && (rd_wp_base == r_addr) &&
                      (rd_wp_len == r_sk);
        bp_pc_hit   = bp_ok && (rd_bp_addr == r_addr) && (rd_bp_kind == BP_KIND_HIT);

        // Half-open range [base, base+length) with a 33-bit end.
        wp_end      = {1'b0, rd_wp_base} + {17'd0, rd_wp_len};
        wp_type_ok  = (rd_wp_type == WPT_ACCESS) ||
                      (rd_wp_type == (r_wr ? WPT_WRITE : WPT_READ));
        wp_data_hit = wp_ok && wp_type_ok && (chk_addr >= rd_wp_base) &&
                      ({1'b0, chk_addr} < wp_end);

        // First free slot of the selected table, in scan order.
        ins_slot    = !r_found && (use_bp ? !r_bp_valid[bp_ci] : !r_wp_valid[wp_ci]);
        ins_write   = r_cmp_en && (r_op == OP_INSERT) && ins_slot;

        out_free    = !r_out_valid || i_out_ready;

        unique case (r_op)
            OP_INSERT: n_status = no_scan ? ST_UNSUPPORTED : (r_found ? ST_OK : ST_FULL);
            OP_REMOVE: n_status = no_scan ? ST_UNSUPPORTED : ST_OK;
            OP_DCHECK: n_status = ST_OK;
            OP_PCHECK: n_status = ST_OK;
            default:   n_status = ST_OK;
        endcase
    end

    assign o_stat.no_scan  = no_scan;
    assign o_stat.use_bp   = use_bp;
    assign o_stat.out_free = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_hit           = r_hit;

    // Item capture, read stage and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_kind);
            r_ptype <= i_point_type;
            r_addr  <= i_address;
            r_sk    <= i_size_or_kind;
            r_wr    <= i_access_is_write;
            r_io    <= i_io_space;
        end
        if (i_cmd.rd_en) begin
            if (use_bp) begin
                r_rd_bp <= r_bp_mem[i_rd_idx[BP_IW-1:0]];
            end else begin
                r_rd_wp <= r_wp_mem[i_rd_idx[WP_IW-1:0]];
            end
        end
        r_cmp_idx <= i_rd_idx;
        if (i_cmd.out_load) begin
            r_status <= n_status;
            r_hit    <= r_found && ((r_op == OP_DCHECK) || (r_op == OP_PCHECK));
        end
    end

    // Table memories, written by insert only.
    always_ff @(posedge i_clk) begin
        if (ins_write) begin
            if (use_bp) begin
                r_bp_mem[bp_ci] <= {r_addr, r_sk};
            end else begin
                r_wp_mem[wp_ci] <= {new_wp_type, r_addr, r_sk};
            end
        end
    end

    // Control state: valid bits, compare enable, match flag, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp_valid  <= '0;
            r_wp_valid  <= '0;
            r_cmp_en    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (r_cmp_en) begin
                case (r_op)
                    OP_INSERT: begin
                        if (ins_slot) begin
                            r_found <= 1'b1;
                            if (use_bp) begin
                                r_bp_valid[bp_ci] <= 1'b1;
                            end else begin
                                r_wp_valid[wp_ci] <= 1'b1;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (bp_same) begin
                            r_bp_valid[bp_ci] <= 1'b0;
                        end
                        if (wp_same) begin
                            r_wp_valid[wp_ci] <= 1'b0;
                        end
                    end
                    OP_DCHECK: begin
                        if (wp_data_hit) begin
                            r_found <= 1'b1;
                        end
                    end
                    OP_PCHECK: begin
                        if (bp_pc_hit) begin
                            r_found <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/dwbu_ctrl.sv -----
// Controller: accepts one item, walks the selected table unless the item needs no walk, hands off the result.
module dwbu_ctrl import dwbu_pkg::*; #(
    parameter int BP_ENTRIES = BP_ENTRIES_DEF,
    parameter int WP_ENTRIES = WP_ENTRIES_DEF,
    parameter int CW         = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_stat         i_stat,
    output t_cmd          o_cmd,
    output logic [CW-1:0] o_rd_idx
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] last_idx;

    always_comb begin
        last_idx       = i_stat.use_bp ? CW'(BP_ENTRIES - 1) : CW'(WP_ENTRIES - 1);
        o_in_ready     = (r_state == S_IDLE);
        o_cmd.load     = i_in_valid && (r_state == S_IDLE);
        o_cmd.rd_en    = (r_state == S_SCAN);
        o_cmd.out_load = (r_state == S_DONE) && i_stat.out_free;
        o_rd_idx       = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_idx <= '0;
                    if (i_stat.no_scan) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == last_idx) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FLUSH: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
